FILE: rtl/miu_pkg.sv
// miu_pkg: shared types, opcodes and command structs for the integer execute unit
// no dependencies
`default_nettype none
package miu_pkg;

    localparam int unsigned DataWidth = 32;
    localparam int unsigned RegCount  = 32;
    localparam int unsigned IdxWidth  = 5;

    // primary opcodes
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTI    = 6'h0A;
    localparam logic [5:0] OP_SLTIU   = 6'h0B;
    localparam logic [5:0] OP_ANDI    = 6'h0C;
    localparam logic [5:0] OP_ORI     = 6'h0D;
    localparam logic [5:0] OP_XORI    = 6'h0E;
    localparam logic [5:0] OP_LUI     = 6'h0F;
    localparam logic [5:0] OP_NOP1C   = 6'h1C;
    localparam logic [5:0] OP_SPEC3   = 6'h1F;
    localparam logic [5:0] OP_CACHE   = 6'h2F;
    localparam logic [5:0] OP_NOP3F   = 6'h3F;

    // special functions
    localparam logic [5:0] FN_SLL   = 6'h00;
    localparam logic [5:0] FN_SRL   = 6'h02;
    localparam logic [5:0] FN_SRA   = 6'h03;
    localparam logic [5:0] FN_SLLV  = 6'h04;
    localparam logic [5:0] FN_SRLV  = 6'h06;
    localparam logic [5:0] FN_SRAV  = 6'h07;
    localparam logic [5:0] FN_MOVZ  = 6'h0A;
    localparam logic [5:0] FN_MOVN  = 6'h0B;
    localparam logic [5:0] FN_SYNC  = 6'h0F;
    localparam logic [5:0] FN_MFHI  = 6'h10;
    localparam logic [5:0] FN_MTHI  = 6'h11;
    localparam logic [5:0] FN_MFLO  = 6'h12;
    localparam logic [5:0] FN_MTLO  = 6'h13;
    localparam logic [5:0] FN_CLZ   = 6'h16;
    localparam logic [5:0] FN_CLO   = 6'h17;
    localparam logic [5:0] FN_MULT  = 6'h18;
    localparam logic [5:0] FN_MULTU = 6'h19;
    localparam logic [5:0] FN_DIV   = 6'h1A;
    localparam logic [5:0] FN_DIVU  = 6'h1B;
    localparam logic [5:0] FN_MADD  = 6'h1C;
    localparam logic [5:0] FN_MADDU = 6'h1D;
    localparam logic [5:0] FN_ADD   = 6'h20;
    localparam logic [5:0] FN_ADDU  = 6'h21;
    localparam logic [5:0] FN_SUB   = 6'h22;
    localparam logic [5:0] FN_SUBU  = 6'h23;
    localparam logic [5:0] FN_AND   = 6'h24;
    localparam logic [5:0] FN_OR    = 6'h25;
    localparam logic [5:0] FN_XOR   = 6'h26;
    localparam logic [5:0] FN_NOR   = 6'h27;
    localparam logic [5:0] FN_SLT   = 6'h2A;
    localparam logic [5:0] FN_SLTU  = 6'h2B;
    localparam logic [5:0] FN_MAX   = 6'h2C;
    localparam logic [5:0] FN_MIN   = 6'h2D;
    localparam logic [5:0] FN_MSUB  = 6'h2E;
    localparam logic [5:0] FN_MSUBU = 6'h2F;

    // special3 functions and bshfl subcodes
    localparam logic [5:0] F3_EXT   = 6'h00;
    localparam logic [5:0] F3_INS   = 6'h04;
    localparam logic [5:0] F3_BSHFL = 6'h20;
    localparam logic [4:0] BS_WSBH  = 5'h02;
    localparam logic [4:0] BS_WSBW  = 5'h03;
    localparam logic [4:0] BS_SEB   = 5'h10;
    localparam logic [4:0] BS_BITREV = 5'h14;
    localparam logic [4:0] BS_SEH   = 5'h18;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } t_state;

    // long operation kinds
    typedef enum logic [1:0] {
        LK_NONE,
        LK_MUL,
        LK_DIV
    } t_long;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture instruction word
        logic exec;      // single-cycle execute and commit
        logic mul_step;  // one partial product step
        logic div_start; // set up the divider
        logic div_step;  // one quotient bit
        logic fin;       // commit long-op result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        t_long kind;
        logic  mul_last;
        logic  div_last;
    } t_stat;

endpackage
`default_nettype wire

FILE: rtl/miu_if.sv
// miu_stream_if: valid/ready channel carrying one payload
// no dependencies
`default_nettype none
interface miu_stream_if #(
    parameter int unsigned Width = 32
);
    logic             valid;
    logic             ready;
    logic [Width-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/mips_integer_execute_unit.sv
// mips_integer_execute_unit: top level, binds the controller and datapath
// depends on miu_pkg, miu_stream_if, miu_ctrl, miu_dp
// sequence: accept loads the word, registers are read, then mult/madd/msub take four 32x8
// partial product steps and div/divu one quotient bit a cycle, then execute and commit
// throughput: one transaction at a time, the next accepted in the cycle after the
// result is taken
// reset: synchronous active low, clears hi, lo and all register valid bits (all zero)
`default_nettype none
module mips_integer_execute_unit (
    input wire logic i_clk,
    input wire logic i_rst_n,
    miu_stream_if.sink   in_ch,
    miu_stream_if.source out_ch
);
    miu_pkg::t_cmd  cmd;
    miu_pkg::t_stat stat;
    logic           out_valid;

    // payload packing of the result: wr_en, wr_index, wr_value, hi, lo, illegal
    logic        wr_en, illegal;
    logic [4:0]  wr_index;
    logic [31:0] wr_value, hi_value, lo_value;

    miu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_ch.valid),
        .o_in_ready  (in_ch.ready),
        .o_out_valid (out_valid),
        .i_out_ready (out_ch.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    miu_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_instr    (in_ch.data),
        .o_wr_en    (wr_en),
        .o_wr_index (wr_index),
        .o_wr_value (wr_value),
        .o_hi_value (hi_value),
        .o_lo_value (lo_value),
        .o_illegal  (illegal)
    );

    assign out_ch.valid = out_valid;
    assign out_ch.data  = {wr_en, wr_index, wr_value, hi_value, lo_value, illegal};
endmodule
`default_nettype wire

FILE: rtl/miu_ctrl.sv
// miu_ctrl: sequencing state machine for the execute unit
// depends on miu_pkg
`default_nettype none
module miu_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    input  wire miu_pkg::t_stat i_stat,
    output miu_pkg::t_cmd      o_cmd
);
    miu_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= miu_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            miu_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = miu_pkg::ST_READ;
                end
            end
            miu_pkg::ST_READ: begin
                // register file read data settles here
                case (i_stat.kind)
                    miu_pkg::LK_MUL: n_state = miu_pkg::ST_MUL;
                    miu_pkg::LK_DIV: begin
                        o_cmd.div_start = 1'b1;
                        n_state         = miu_pkg::ST_DIV;
                    end
                    default: n_state = miu_pkg::ST_EXEC;
                endcase
            end
            miu_pkg::ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = miu_pkg::ST_DONE;
            end
            miu_pkg::ST_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (i_stat.mul_last) begin
                    n_state = miu_pkg::ST_EXEC;
                end
            end
            miu_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = miu_pkg::ST_EXEC;
                end
            end
            miu_pkg::ST_DONE: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = miu_pkg::ST_IDLE;
                end
            end
            default: n_state = miu_pkg::ST_IDLE;
        endcase
        o_cmd.fin = o_cmd.exec;
    end

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({o_cmd.load, o_cmd.exec, o_cmd.mul_step, o_cmd.div_step}) <= 1)
        else $error("more than one datapath command");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == miu_pkg::ST_READ)
        else $error("load did not lead to read");
    a_exec_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> o_out_valid)
        else $error("execute not followed by result");
endmodule
`default_nettype wire

FILE: rtl/miu_dp.sv
// miu_dp: register file, hi/lo, alu, sequential multiplier and divider
// depends on miu_pkg
`default_nettype none
module miu_dp (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire miu_pkg::t_cmd i_cmd,
    output miu_pkg::t_stat     o_stat,
    input  wire logic [31:0]   i_instr,
    output logic               o_wr_en,
    output logic [4:0]         o_wr_index,
    output logic [31:0]        o_wr_value,
    output logic [31:0]        o_hi_value,
    output logic [31:0]        o_lo_value,
    output logic               o_illegal
);
    localparam int unsigned IdxW = $clog2(miu_pkg::RegCount);

    logic [31:0] r_ir;
    logic [31:0] r_gpr [miu_pkg::RegCount];
    logic [miu_pkg::RegCount-1:0] r_gvalid;
    logic [31:0] r_a, r_b;
    logic [31:0] r_hi, r_lo;
    logic        r_wr_en, r_illegal;
    logic [4:0]  r_wr_index;
    logic [31:0] r_wr_value;

    // multiplier: 4 steps of 32x8
    logic [1:0]  r_mcnt;
    logic [63:0] r_prod;
    logic [31:0] r_mb;
    logic        r_msign;
    // divider: restoring, one bit per step
    logic [4:0]  r_dcnt;
    logic [31:0] r_dq, r_dr, r_dd;

    logic [5:0] op, fn;
    logic [4:0] rs, rt, rd, sa;
    logic [15:0] imm;
    assign op  = r_ir[31:26];
    assign fn  = r_ir[5:0];
    assign rs  = r_ir[25:21];
    assign rt  = r_ir[20:16];
    assign rd  = r_ir[15:11];
    assign sa  = r_ir[10:6];
    assign imm = r_ir[15:0];

    // register file, read as the word is loaded, zero-valued until written
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ir <= i_instr;
            r_a  <= (i_instr[25:21] == 5'd0 || !r_gvalid[i_instr[21 +: IdxW]]) ? '0
                  : r_gpr[i_instr[21 +: IdxW]];
            r_b  <= (i_instr[20:16] == 5'd0 || !r_gvalid[i_instr[16 +: IdxW]]) ? '0
                  : r_gpr[i_instr[16 +: IdxW]];
        end
    end

    logic is_mul, is_div, is_signed_mul;
    always_comb begin
        is_mul = (op == miu_pkg::OP_SPECIAL) &&
            (fn == miu_pkg::FN_MULT || fn == miu_pkg::FN_MULTU ||
             fn == miu_pkg::FN_MADD || fn == miu_pkg::FN_MADDU ||
             fn == miu_pkg::FN_MSUB || fn == miu_pkg::FN_MSUBU);
        is_div = (op == miu_pkg::OP_SPECIAL) &&
            (fn == miu_pkg::FN_DIV || fn == miu_pkg::FN_DIVU);
        is_signed_mul = fn == miu_pkg::FN_MULT || fn == miu_pkg::FN_MADD ||
            fn == miu_pkg::FN_MSUB;
        o_stat.kind = is_mul ? miu_pkg::LK_MUL : (is_div ? miu_pkg::LK_DIV
                    : miu_pkg::LK_NONE);
        o_stat.mul_last = r_mcnt == 2'd3;
        o_stat.div_last = r_dcnt == 5'd31;
    end

    // magnitudes for the sequential units
    logic [31:0] mag_a, mag_b;
    logic        div_signed;
    assign div_signed = fn == miu_pkg::FN_DIV;
    always_comb begin
        mag_a = r_a;
        mag_b = r_b;
        if ((is_mul && is_signed_mul) || (is_div && div_signed)) begin
            if (r_a[31]) mag_a = -r_a;
            if (r_b[31]) mag_b = -r_b;
        end
    end

    logic [39:0] pp;
    logic [32:0] trial;
    logic [31:0] rem_sh;
    assign pp     = {8'd0, mag_a} * {32'd0, r_mb[7:0]};
    assign rem_sh = {r_dr[30:0], r_dd[31]};
    assign trial  = {r_dr, r_dd[31]} - {1'b0, mag_b};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mcnt <= '0;
            r_dcnt <= '0;
        end else begin
            if (i_cmd.mul_step) r_mcnt <= r_mcnt + 2'd1;
            if (i_cmd.div_step) r_dcnt <= r_dcnt + 5'd1;
        end
        if (!i_cmd.mul_step) begin
            r_prod  <= '0;
            r_mb    <= mag_b;
            r_msign <= is_signed_mul && (r_a[31] ^ r_b[31]);
        end else begin
            r_prod <= r_prod + ({24'd0, pp} << {r_mcnt, 3'b000});
            r_mb   <= r_mb >> 8;
        end
        if (i_cmd.div_start) begin
            r_dd <= mag_a;
            r_dr <= '0;
            r_dq <= '0;
        end else if (i_cmd.div_step) begin
            r_dd <= {r_dd[30:0], 1'b0};
            if (!trial[32]) begin
                r_dr <= trial[31:0];
                r_dq <= {r_dq[30:0], 1'b1};
            end else begin
                r_dr <= rem_sh;
                r_dq <= {r_dq[30:0], 1'b0};
            end
        end
    end

    // combinational results, committed on exec
    logic        wr, bad;
    logic [4:0]  wi;
    logic [31:0] wv, n_hi, n_lo;
    logic [31:0] se_imm, rmask, imask;
    logic [4:0]  shv;
    logic [63:0] acc, prod;
    logic [5:0]  lz_z, lz_o;
    logic        lt_s;

    function automatic logic [5:0] f_lead_zeros(input logic [31:0] x);
        logic [5:0] n;
        n = 6'd32;
        for (int i = 0; i < 32; i++) begin
            if (x[i]) n = 6'(31 - i);
        end
        return n;
    endfunction

    function automatic logic [31:0] f_low_mask(input logic [5:0] bits);
        return bits[5] ? 32'hFFFF_FFFF : ((32'd1 << bits[4:0]) - 32'd1);
    endfunction

    always_comb begin
        se_imm = {{16{imm[15]}}, imm};
        lt_s   = (r_a ^ 32'h8000_0000) < (r_b ^ 32'h8000_0000);
        lz_z   = f_lead_zeros(r_a);
        lz_o   = f_lead_zeros(~r_a);
        prod   = r_msign ? -r_prod : r_prod;
        acc    = {r_hi, r_lo};
        shv    = r_a[4:0];
        rmask  = f_low_mask({1'b0, rd} + 6'd1);
        imask  = (rd < sa) ? '0 : f_low_mask(6'({1'b0, rd} + 6'd1 - {1'b0, sa}));
        wr = 1'b0; bad = 1'b0; wi = rd; wv = '0;
        n_hi = r_hi; n_lo = r_lo;
        if (op == miu_pkg::OP_SPECIAL) begin
            case (fn)
                miu_pkg::FN_SLL: begin wr = 1'b1; wv = r_b << sa; end
                miu_pkg::FN_SRL: begin
                    wr = 1'b1;
                    if (rs == 5'd0) wv = r_b >> sa;
                    else if (rs == 5'd1) wv = (r_b >> sa) | (r_b << (6'd32 - {1'b0, sa}));
                    else bad = 1'b1;
                    if (rs == 5'd1 && sa == 5'd0) wv = r_b;
                end
                miu_pkg::FN_SRA: begin wr = 1'b1; wv = $signed(r_b) >>> sa; end
                miu_pkg::FN_SLLV: begin wr = 1'b1; wv = r_b << shv[4:0]; end
                miu_pkg::FN_SRLV: begin
                    wr = 1'b1;
                    if (sa == 5'd0) wv = r_b >> shv[4:0];
                    else if (sa == 5'd1)
                        wv = (shv[4:0] == 5'd0) ? r_b
                           : (r_b >> shv[4:0]) | (r_b << (6'd32 - {1'b0, shv[4:0]}));
                    else bad = 1'b1;
                end
                miu_pkg::FN_SRAV: begin wr = 1'b1; wv = $signed(r_b) >>> shv[4:0]; end
                miu_pkg::FN_MOVZ: begin wr = (r_b == '0); wv = r_a; end
                miu_pkg::FN_MOVN: begin wr = (r_b != '0); wv = r_a; end
                miu_pkg::FN_SYNC: ;
                miu_pkg::FN_MFHI: begin wr = 1'b1; wv = r_hi; end
                miu_pkg::FN_MTHI: n_hi = r_a;
                miu_pkg::FN_MFLO: begin wr = 1'b1; wv = r_lo; end
                miu_pkg::FN_MTLO: n_lo = r_a;
                miu_pkg::FN_CLZ: begin wr = 1'b1; wv = {26'd0, lz_z}; end
                miu_pkg::FN_CLO: begin wr = 1'b1; wv = {26'd0, lz_o}; end
                miu_pkg::FN_MULT, miu_pkg::FN_MULTU: {n_hi, n_lo} = prod;
                miu_pkg::FN_MADD, miu_pkg::FN_MADDU: {n_hi, n_lo} = acc + prod;
                miu_pkg::FN_MSUB, miu_pkg::FN_MSUBU: {n_hi, n_lo} = acc - prod;
                miu_pkg::FN_DIV: begin
                    if (r_a == 32'h8000_0000 && r_b == 32'hFFFF_FFFF) begin
                        n_lo = 32'h8000_0000; n_hi = 32'hFFFF_FFFF;
                    end else if (r_b != '0) begin
                        n_lo = (r_a[31] ^ r_b[31]) ? -r_dq : r_dq;
                        n_hi = r_a[31] ? -r_dr : r_dr;
                    end else begin
                        n_lo = r_a[31] ? 32'd1 : 32'hFFFF_FFFF;
                        n_hi = r_a;
                    end
                end
                miu_pkg::FN_DIVU: begin
                    if (r_b != '0) begin
                        n_lo = r_dq; n_hi = r_dr;
                    end else begin
                        n_lo = (r_a <= 32'hFFFF) ? 32'h0000_FFFF : 32'hFFFF_FFFF;
                        n_hi = r_a;
                    end
                end
                miu_pkg::FN_ADD, miu_pkg::FN_ADDU: begin wr = 1'b1; wv = r_a + r_b; end
                miu_pkg::FN_SUB, miu_pkg::FN_SUBU: begin wr = 1'b1; wv = r_a - r_b; end
                miu_pkg::FN_AND: begin wr = 1'b1; wv = r_a & r_b; end
                miu_pkg::FN_OR:  begin wr = 1'b1; wv = r_a | r_b; end
                miu_pkg::FN_XOR: begin wr = 1'b1; wv = r_a ^ r_b; end
                miu_pkg::FN_NOR: begin wr = 1'b1; wv = ~(r_a | r_b); end
                miu_pkg::FN_SLT: begin wr = 1'b1; wv = {31'd0, lt_s}; end
                miu_pkg::FN_SLTU: begin wr = 1'b1; wv = {31'd0, r_a < r_b}; end
                miu_pkg::FN_MAX: begin wr = 1'b1; wv = lt_s ? r_b : r_a; end
                miu_pkg::FN_MIN: begin wr = 1'b1; wv = lt_s ? r_a : r_b; end
                default: bad = 1'b1;
            endcase
        end else begin
            wi = rt;
            case (op)
                miu_pkg::OP_ADDIU: begin wr = 1'b1; wv = r_a + se_imm; end
                miu_pkg::OP_SLTI: begin
                    wr = 1'b1;
                    wv = {31'd0, (r_a ^ 32'h8000_0000) < (se_imm ^ 32'h8000_0000)};
                end
                miu_pkg::OP_SLTIU: begin wr = 1'b1; wv = {31'd0, r_a < se_imm}; end
                miu_pkg::OP_ANDI: begin wr = 1'b1; wv = r_a & {16'd0, imm}; end
                miu_pkg::OP_ORI:  begin wr = 1'b1; wv = r_a | {16'd0, imm}; end
                miu_pkg::OP_XORI: begin wr = 1'b1; wv = r_a ^ {16'd0, imm}; end
                miu_pkg::OP_LUI:  begin wr = 1'b1; wv = {imm, 16'd0}; end
                miu_pkg::OP_NOP1C, miu_pkg::OP_CACHE, miu_pkg::OP_NOP3F: ;
                miu_pkg::OP_SPEC3: begin
                    case (fn)
                        miu_pkg::F3_EXT: begin wr = 1'b1; wv = (r_a >> sa) & rmask; end
                        miu_pkg::F3_INS: begin
                            wr = 1'b1;
                            wv = (r_b & ~(imask << sa)) | ((r_a & imask) << sa);
                        end
                        miu_pkg::F3_BSHFL: begin
                            wi = rd;
                            wr = 1'b1;
                            case (sa)
                                miu_pkg::BS_WSBH: wv = {r_b[23:16], r_b[31:24],
                                                        r_b[7:0], r_b[15:8]};
                                miu_pkg::BS_WSBW: wv = {r_b[7:0], r_b[15:8],
                                                        r_b[23:16], r_b[31:24]};
                                miu_pkg::BS_SEB: wv = {{24{r_b[7]}}, r_b[7:0]};
                                miu_pkg::BS_SEH: wv = {{16{r_b[15]}}, r_b[15:0]};
                                miu_pkg::BS_BITREV: wv = {<<{r_b}};
                                default: bad = 1'b1;
                            endcase
                        end
                        default: bad = 1'b1;
                    endcase
                end
                default: bad = 1'b1;
            endcase
        end
        if (bad || wi == 5'd0 || !wr) begin
            wr = 1'b0; wi = '0; wv = '0;
        end
        if (bad) begin
            n_hi = r_hi; n_lo = r_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hi      <= '0;
            r_lo      <= '0;
            r_gvalid  <= '0;
            r_wr_en   <= 1'b0;
            r_illegal <= 1'b0;
        end else if (i_cmd.exec) begin
            r_hi      <= n_hi;
            r_lo      <= n_lo;
            r_wr_en   <= wr;
            r_illegal <= bad;
            if (wr) r_gvalid[wi[IdxW-1:0]] <= 1'b1;
        end
        if (i_cmd.exec) begin
            if (wr) r_gpr[wi[IdxW-1:0]] <= wv;
            r_wr_index <= wi;
            r_wr_value <= wv;
        end
    end

    assign o_wr_en    = r_wr_en;
    assign o_wr_index = r_wr_index;
    assign o_wr_value = r_wr_value;
    assign o_hi_value = r_hi;
    assign o_lo_value = r_lo;
    assign o_illegal  = r_illegal;

    a_no_wr_on_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec && bad |=> !r_wr_en && $stable(r_hi) && $stable(r_lo))
        else $error("illegal instruction changed state");
    a_no_r0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_en |-> r_wr_index != 5'd0)
        else $error("write to register zero");
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |=> r_dcnt == 5'd0)
        else $error("divider count not at zero on start");
endmodule
`default_nettype wire

FILE: dv/tb_top.sv
// tb_top: self-checking bench for the integer execute unit
// depends on miu_pkg, miu_stream_if and mips_integer_execute_unit from rtl
// directed table first, then random instruction mix, checked by an in-bench predictor
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // result layout on the output channel, first field in the top bits
    typedef struct packed {
        logic        wr_en;
        logic [4:0]  wr_index;
        logic [31:0] wr_value;
        logic [31:0] hi_value;
        logic [31:0] lo_value;
        logic        illegal;
    } t_result;

    localparam int unsigned ResWidth = $bits(t_result);

    // encodings the block must refuse
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] FN_JR      = 6'h08;
    localparam logic [5:0] F3_UNKNOWN = 6'h01;
    localparam logic [4:0] BS_UNKNOWN = 5'h05;

    logic i_clk;
    logic i_rst_n;

    miu_stream_if #(.Width(32))       in_ch ();
    miu_stream_if #(.Width(ResWidth)) out_ch ();

    mips_integer_execute_unit i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // predictor state: architectural registers as the block should hold them
    logic [31:0] arch_gpr [32];
    logic [31:0] arch_hi;
    logic [31:0] arch_lo;

    t_result result_q [$];  // results still owed by the block
    t_result typed_q [$];   // hand-written results for directed rows
    bit      typed_flag_q [$];
    bit      failed;
    int      tx_idle_pct;
    int      rx_stall_pct;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // hard ceiling on the run
    initial begin
        #20ms;
        $display("FAIL mips_integer_execute_unit");
        $finish;
    end

    // ---------------------------------------------------------------- encoders
    function automatic logic [31:0] r_word(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                          logic [4:0] rd, logic [4:0] sa);
        return {miu_pkg::OP_SPECIAL, rs, rt, rd, sa, fn};
    endfunction

    function automatic logic [31:0] i_word(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                          logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    function automatic logic [31:0] s3_word(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                           logic [4:0] rd, logic [4:0] sa);
        return {miu_pkg::OP_SPEC3, rs, rt, rd, sa, fn};
    endfunction

    // ---------------------------------------------------------------- predictor helpers
    function automatic logic [31:0] rotate_right(logic [31:0] x, logic [4:0] s);
        return (s == 0) ? x : ((x >> s) | (x << (6'd32 - s)));
    endfunction

    function automatic logic [31:0] count_leading_zeros(logic [31:0] x);
        int n;
        n = 0;
        while (n < 32 && !x[31 - n]) n++;
        return n;
    endfunction

    function automatic logic [31:0] ones_below(int unsigned bits);
        logic [32:0] m;
        m = (33'd1 << bits) - 33'd1;
        return (bits >= 32) ? 32'hFFFF_FFFF : m[31:0];
    endfunction

    function automatic logic [31:0] sext_half(logic [31:0] x);
        return {{16{x[15]}}, x[15:0]};
    endfunction

    function automatic logic signed_less(logic [31:0] a, logic [31:0] b);
        return $signed(a) < $signed(b);
    endfunction

    // executes one instruction against the predictor state and returns its result
    function automatic t_result execute_instr(logic [31:0] w);
        t_result     r;
        logic [5:0]  op, fn;
        logic [4:0]  rs, rt, rd, sa;
        logic [31:0] a, b, imm, m;
        logic [63:0] acc, prod_s, prod_u;
        longint      x, y;
        logic        wr, bad;
        logic [4:0]  wi;
        logic [31:0] wv;

        op  = w[31:26]; fn = w[5:0];
        rs  = w[25:21]; rt = w[20:16]; rd = w[15:11]; sa = w[10:6];
        a   = (rs == 0) ? 32'd0 : arch_gpr[rs];
        b   = (rt == 0) ? 32'd0 : arch_gpr[rt];
        imm = {16'd0, w[15:0]};
        wr  = 1'b0; bad = 1'b0; wi = '0; wv = '0;
        acc    = {arch_hi, arch_lo};
        prod_s = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
        prod_u = {32'd0, a} * {32'd0, b};

        if (op == miu_pkg::OP_SPECIAL) begin
            case (fn)
                miu_pkg::FN_SLL:  begin wr = 1; wi = rd; wv = b << sa; end
                miu_pkg::FN_SRL: begin
                    if (rs == 0) begin wr = 1; wi = rd; wv = b >> sa; end
                    else if (rs == 1) begin wr = 1; wi = rd; wv = rotate_right(b, sa); end
                    else bad = 1;
                end
                miu_pkg::FN_SRA:  begin wr = 1; wi = rd; wv = $signed(b) >>> sa; end
                miu_pkg::FN_SLLV: begin wr = 1; wi = rd; wv = b << a[4:0]; end
                miu_pkg::FN_SRLV: begin
                    if (sa == 0) begin wr = 1; wi = rd; wv = b >> a[4:0]; end
                    else if (sa == 1) begin
                        wr = 1; wi = rd; wv = rotate_right(b, a[4:0]);
                    end
                    else bad = 1;
                end
                miu_pkg::FN_SRAV: begin wr = 1; wi = rd; wv = $signed(b) >>> a[4:0]; end
                miu_pkg::FN_MOVZ: if (b == 0) begin wr = 1; wi = rd; wv = a; end
                miu_pkg::FN_MOVN: if (b != 0) begin wr = 1; wi = rd; wv = a; end
                miu_pkg::FN_SYNC: ;
                miu_pkg::FN_MFHI: begin wr = 1; wi = rd; wv = arch_hi; end
                miu_pkg::FN_MTHI: arch_hi = a;
                miu_pkg::FN_MFLO: begin wr = 1; wi = rd; wv = arch_lo; end
                miu_pkg::FN_MTLO: arch_lo = a;
                miu_pkg::FN_CLZ:  begin wr = 1; wi = rd; wv = count_leading_zeros(a); end
                miu_pkg::FN_CLO:  begin wr = 1; wi = rd; wv = count_leading_zeros(~a); end
                miu_pkg::FN_MULT:  {arch_hi, arch_lo} = prod_s;
                miu_pkg::FN_MULTU: {arch_hi, arch_lo} = prod_u;
                miu_pkg::FN_MADD:  {arch_hi, arch_lo} = acc + prod_s;
                miu_pkg::FN_MADDU: {arch_hi, arch_lo} = acc + prod_u;
                miu_pkg::FN_MSUB:  {arch_hi, arch_lo} = acc - prod_s;
                miu_pkg::FN_MSUBU: {arch_hi, arch_lo} = acc - prod_u;
                miu_pkg::FN_DIV: begin
                    if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) begin
                        arch_lo = 32'h8000_0000; arch_hi = 32'hFFFF_FFFF;
                    end else if (b != 0) begin
                        x = $signed(a); y = $signed(b);
                        arch_lo = 32'(x / y); arch_hi = 32'(x % y);
                    end else begin
                        arch_lo = a[31] ? 32'd1 : 32'hFFFF_FFFF; arch_hi = a;
                    end
                end
                miu_pkg::FN_DIVU: begin
                    if (b != 0) begin arch_lo = a / b; arch_hi = a % b; end
                    else begin
                        arch_lo = (a <= 32'hFFFF) ? 32'hFFFF : 32'hFFFF_FFFF; arch_hi = a;
                    end
                end
                miu_pkg::FN_ADD, miu_pkg::FN_ADDU: begin wr = 1; wi = rd; wv = a + b; end
                miu_pkg::FN_SUB, miu_pkg::FN_SUBU: begin wr = 1; wi = rd; wv = a - b; end
                miu_pkg::FN_AND:  begin wr = 1; wi = rd; wv = a & b; end
                miu_pkg::FN_OR:   begin wr = 1; wi = rd; wv = a | b; end
                miu_pkg::FN_XOR:  begin wr = 1; wi = rd; wv = a ^ b; end
                miu_pkg::FN_NOR:  begin wr = 1; wi = rd; wv = ~(a | b); end
                miu_pkg::FN_SLT:  begin wr = 1; wi = rd; wv = signed_less(a, b); end
                miu_pkg::FN_SLTU: begin wr = 1; wi = rd; wv = (a < b); end
                miu_pkg::FN_MAX:  begin wr = 1; wi = rd; wv = signed_less(a, b) ? b : a; end
                miu_pkg::FN_MIN:  begin wr = 1; wi = rd; wv = signed_less(a, b) ? a : b; end
                default: bad = 1;
            endcase
        end else begin
            case (op)
                miu_pkg::OP_ADDIU: begin wr = 1; wi = rt; wv = a + sext_half(imm); end
                miu_pkg::OP_SLTI: begin
                    wr = 1; wi = rt; wv = signed_less(a, sext_half(imm));
                end
                miu_pkg::OP_SLTIU: begin wr = 1; wi = rt; wv = (a < sext_half(imm)); end
                miu_pkg::OP_ANDI:  begin wr = 1; wi = rt; wv = a & imm; end
                miu_pkg::OP_ORI:   begin wr = 1; wi = rt; wv = a | imm; end
                miu_pkg::OP_XORI:  begin wr = 1; wi = rt; wv = a ^ imm; end
                miu_pkg::OP_LUI:   begin wr = 1; wi = rt; wv = imm << 16; end
                miu_pkg::OP_NOP1C, miu_pkg::OP_CACHE, miu_pkg::OP_NOP3F: ;
                miu_pkg::OP_SPEC3: begin
                    if (fn == miu_pkg::F3_EXT) begin
                        wr = 1; wi = rt; wv = (a >> sa) & ones_below(rd + 1);
                    end else if (fn == miu_pkg::F3_INS) begin
                        m  = (rd < sa) ? 32'd0 : ones_below(rd + 1 - sa);
                        wr = 1; wi = rt; wv = (b & ~(m << sa)) | ((a & m) << sa);
                    end else if (fn == miu_pkg::F3_BSHFL) begin
                        case (sa)
                            miu_pkg::BS_WSBH: begin
                                wr = 1; wi = rd; wv = {b[23:16], b[31:24], b[7:0], b[15:8]};
                            end
                            miu_pkg::BS_WSBW: begin
                                wr = 1; wi = rd; wv = {b[7:0], b[15:8], b[23:16], b[31:24]};
                            end
                            miu_pkg::BS_SEB: begin
                                wr = 1; wi = rd; wv = {{24{b[7]}}, b[7:0]};
                            end
                            miu_pkg::BS_SEH: begin wr = 1; wi = rd; wv = sext_half(b); end
                            miu_pkg::BS_BITREV: begin
                                wr = 1; wi = rd;
                                for (int i = 0; i < 32; i++) wv[31 - i] = b[i];
                            end
                            default: bad = 1;
                        endcase
                    end else begin
                        bad = 1;
                    end
                end
                default: bad = 1;
            endcase
        end

        // register zero swallows writes, and a refused encoding commits nothing
        if (bad || wi == 0) begin wr = 0; wi = 0; wv = 0; end
        if (wr) arch_gpr[wi] = wv;

        r.wr_en = wr; r.wr_index = wi; r.wr_value = wv;
        r.hi_value = arch_hi; r.lo_value = arch_lo; r.illegal = bad;
        return r;
    endfunction

    // ---------------------------------------------------------------- random instruction mix
    function automatic logic [31:0] random_instr();
        logic [4:0] rs, rt, rd, sa;
        logic [15:0] imm;
        logic [5:0] fns [30];
        logic [4:0] bsh [5];
        fns = '{miu_pkg::FN_SLL, miu_pkg::FN_SRL, miu_pkg::FN_SRA, miu_pkg::FN_SLLV,
                miu_pkg::FN_SRLV, miu_pkg::FN_SRAV, miu_pkg::FN_MOVZ, miu_pkg::FN_MOVN,
                miu_pkg::FN_SYNC, miu_pkg::FN_MFHI, miu_pkg::FN_MTHI, miu_pkg::FN_MFLO,
                miu_pkg::FN_MTLO, miu_pkg::FN_CLZ, miu_pkg::FN_CLO, miu_pkg::FN_MULT,
                miu_pkg::FN_MULTU, miu_pkg::FN_DIV, miu_pkg::FN_DIVU, miu_pkg::FN_MADD,
                miu_pkg::FN_MADDU, miu_pkg::FN_ADDU, miu_pkg::FN_SUBU, miu_pkg::FN_AND,
                miu_pkg::FN_OR, miu_pkg::FN_XOR, miu_pkg::FN_NOR, miu_pkg::FN_SLT,
                miu_pkg::FN_MAX, miu_pkg::FN_MSUBU};
        bsh = '{miu_pkg::BS_WSBH, miu_pkg::BS_WSBW, miu_pkg::BS_SEB, miu_pkg::BS_SEH,
                miu_pkg::BS_BITREV};
        // lean on a few registers so results feed later operands
        rs  = ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(7));
        rt  = ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(7));
        rd  = ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(7));
        sa  = 5'($urandom);
        imm = 16'($urandom);
        case ($urandom_range(19))
            0, 1, 2, 3, 4, 5: begin
                case (fns[$urandom_range(29)])
                    miu_pkg::FN_SRL:
                        return r_word(miu_pkg::FN_SRL, 5'($urandom_range(1)), rt, rd, sa);
                    miu_pkg::FN_SRLV:
                        return r_word(miu_pkg::FN_SRLV, rs, rt, rd, 5'($urandom_range(1)));
                    miu_pkg::FN_SUB:
                        return r_word(miu_pkg::FN_SUB, rs, rt, rd, 5'd0);
                    default: return r_word(fns[$urandom_range(29)], rs, rt, rd, sa);
                endcase
            end
            6:  return r_word(miu_pkg::FN_ADD, rs, rt, rd, 5'd0);
            7:  return r_word(miu_pkg::FN_SUB, rs, rt, rd, 5'd0);
            8:  return r_word(miu_pkg::FN_SLTU, rs, rt, rd, 5'd0);
            9:  return r_word(miu_pkg::FN_MIN, rs, rt, rd, 5'd0);
            10: return r_word(miu_pkg::FN_MSUB, rs, rt, rd, 5'd0);
            11: return i_word(miu_pkg::OP_LUI, rs, rt, imm);
            12: return i_word(miu_pkg::OP_ORI, rs, rt, imm);
            13: return i_word($urandom_range(1) ? miu_pkg::OP_ADDIU : miu_pkg::OP_XORI,
                              rs, rt, imm);
            14: return i_word($urandom_range(1) ? miu_pkg::OP_SLTI : miu_pkg::OP_SLTIU,
                              rs, rt, imm);
            15: return i_word(miu_pkg::OP_ANDI, rs, rt, imm);
            16: return s3_word($urandom_range(1) ? miu_pkg::F3_EXT : miu_pkg::F3_INS,
                               rs, rt, rd, sa);
            17: return s3_word(miu_pkg::F3_BSHFL, rs, rt, rd, bsh[$urandom_range(4)]);
            18: return r_word($urandom_range(1) ? miu_pkg::FN_DIV : miu_pkg::FN_DIVU, rs,
                              $urandom_range(3) == 0 ? 5'd0 : rt, rd, sa);
            default: return $urandom;  // raw word, mostly refused encodings
        endcase
    endfunction

    // ---------------------------------------------------------------- driving
    task automatic send_instr(logic [31:0] w, bit use_typed, t_result typed);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid = 1'b0;
            in_ch.data  = 32'($urandom);
            @(negedge i_clk);
        end
        typed_q.push_back(typed);
        typed_flag_q.push_back(use_typed);
        in_ch.valid = 1'b1;
        in_ch.data  = w;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    // receiver back-pressure, redrawn every cycle
    always @(negedge i_clk) out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);

    // input side: predict on each accepted transaction
    always @(posedge i_clk) begin
        t_result p, t;
        bit      f;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            p = execute_instr(in_ch.data);
            t = typed_q.pop_front();
            f = typed_flag_q.pop_front();
            result_q.push_back(f ? t : p);
        end
    end

    // output side: compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.data;
            if (result_q.size() == 0) begin
                $display("%0t: unexpected result %h", $realtime, got);
                failed = 1'b1;
            end else begin
                want = result_q.pop_front();
                if (got.wr_en !== want.wr_en)
                    $display("%0t: wr_en exp %h got %h", $realtime, want.wr_en, got.wr_en);
                if (got.wr_index !== want.wr_index)
                    $display("%0t: wr_index exp %h got %h", $realtime, want.wr_index,
                             got.wr_index);
                if (got.wr_value !== want.wr_value)
                    $display("%0t: wr_value exp %h got %h", $realtime, want.wr_value,
                             got.wr_value);
                if (got.hi_value !== want.hi_value)
                    $display("%0t: hi exp %h got %h", $realtime, want.hi_value, got.hi_value);
                if (got.lo_value !== want.lo_value)
                    $display("%0t: lo exp %h got %h", $realtime, want.lo_value, got.lo_value);
                if (got.illegal !== want.illegal)
                    $display("%0t: illegal exp %h got %h", $realtime, want.illegal,
                             got.illegal);
                if (got !== want) failed = 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- stimulus
    initial begin
        logic [31:0] dir_word [$];
        bit          dir_typed [$];
        t_result     dir_exp [$];
        t_result     none;
        int          wait_cycles;

        failed       = 1'b0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        none         = '0;
        for (int i = 0; i < 32; i++) arch_gpr[i] = '0;
        arch_hi = '0;
        arch_lo = '0;
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table: word, whether the result is typed in, typed result
        // fresh after reset hi reads zero
        dir_word.push_back(r_word(miu_pkg::FN_MFHI, 0, 0, 1, 0));
        dir_typed.push_back(1); dir_exp.push_back('{1, 1, 0, 0, 0, 0});
        dir_word.push_back(i_word(miu_pkg::OP_LUI, 0, 2, 16'h8000));
        dir_typed.push_back(1); dir_exp.push_back('{1, 2, 32'h8000_0000, 0, 0, 0});
        dir_word.push_back(i_word(miu_pkg::OP_ADDIU, 0, 3, 16'hFFFF));
        dir_typed.push_back(1); dir_exp.push_back('{1, 3, 32'hFFFF_FFFF, 0, 0, 0});
        // most negative over minus one
        dir_word.push_back(r_word(miu_pkg::FN_DIV, 2, 3, 0, 0));
        dir_typed.push_back(1);
        dir_exp.push_back('{0, 0, 0, 32'hFFFF_FFFF, 32'h8000_0000, 0});
        // signed divide by zero with negative dividend
        dir_word.push_back(r_word(miu_pkg::FN_DIV, 3, 0, 0, 0));
        dir_typed.push_back(1); dir_exp.push_back('{0, 0, 0, 32'hFFFF_FFFF, 1, 0});
        // unsigned divide by zero, small and large dividend
        dir_word.push_back(r_word(miu_pkg::FN_DIVU, 4, 0, 0, 0));
        dir_typed.push_back(1); dir_exp.push_back('{0, 0, 0, 0, 32'hFFFF, 0});
        dir_word.push_back(r_word(miu_pkg::FN_DIVU, 3, 0, 0, 0));
        dir_typed.push_back(1);
        dir_exp.push_back('{0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0});
        // counts of all-zero and all-one words
        dir_word.push_back(r_word(miu_pkg::FN_CLZ, 0, 0, 5, 0));
        dir_typed.push_back(1);
        dir_exp.push_back('{1, 5, 32, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0});
        dir_word.push_back(r_word(miu_pkg::FN_CLO, 3, 0, 6, 0));
        dir_typed.push_back(1);
        dir_exp.push_back('{1, 6, 32, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0});
        // sltiu sign-extends its immediate
        dir_word.push_back(i_word(miu_pkg::OP_SLTIU, 0, 7, 16'hFFFF));
        dir_typed.push_back(1);
        dir_exp.push_back('{1, 7, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0});
        // write to register zero is dropped
        dir_word.push_back(i_word(miu_pkg::OP_ORI, 3, 0, 16'h1234));
        dir_typed.push_back(1);
        dir_exp.push_back('{0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0});
        // movz and movn with failing condition
        dir_word.push_back(r_word(miu_pkg::FN_MOVZ, 2, 3, 8, 0));
        dir_typed.push_back(1);
        dir_exp.push_back('{0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0});
        dir_word.push_back(r_word(miu_pkg::FN_MOVN, 2, 0, 8, 0));
        dir_typed.push_back(1);
        dir_exp.push_back('{0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0});
        // no-op encodings
        dir_word.push_back(r_word(miu_pkg::FN_SYNC, 0, 0, 0, 0));
        dir_word.push_back(i_word(miu_pkg::OP_CACHE, 3, 9, 16'hFFFF));
        dir_word.push_back(i_word(miu_pkg::OP_NOP1C, 3, 9, 16'h0000));
        dir_word.push_back(i_word(miu_pkg::OP_NOP3F, 31, 31, 16'hFFFF));
        repeat (4) begin
            dir_typed.push_back(1);
            dir_exp.push_back('{0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0});
        end
        // refused encodings: jump, jr, bad shift selectors, unknown special3
        dir_word.push_back(i_word(OP_J, 3, 3, 16'hFFFF));
        dir_word.push_back(r_word(FN_JR, 3, 0, 0, 0));
        dir_word.push_back(r_word(miu_pkg::FN_SRL, 2, 3, 10, 4));
        dir_word.push_back(r_word(miu_pkg::FN_SRLV, 2, 3, 10, 2));
        dir_word.push_back(s3_word(F3_UNKNOWN, 3, 3, 10, 0));
        dir_word.push_back(s3_word(miu_pkg::F3_BSHFL, 0, 3, 10, BS_UNKNOWN));
        repeat (6) begin
            dir_typed.push_back(1);
            dir_exp.push_back('{0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1});
        end
        // inverted ins field, widest ext field, rotate, multiply-accumulate
        dir_word.push_back(s3_word(miu_pkg::F3_INS, 3, 2, 4, 9));
        dir_word.push_back(s3_word(miu_pkg::F3_EXT, 3, 11, 31, 31));
        dir_word.push_back(r_word(miu_pkg::FN_SRL, 1, 2, 12, 31));
        dir_word.push_back(r_word(miu_pkg::FN_MADD, 2, 3, 0, 0));
        dir_word.push_back(r_word(miu_pkg::FN_MSUBU, 3, 3, 0, 0));
        repeat (5) begin
            dir_typed.push_back(0);
            dir_exp.push_back(none);
        end

        foreach (dir_word[i]) send_instr(dir_word[i], dir_typed[i], dir_exp[i]);

        // random part over four phases of sender idling and receiver back-pressure
        for (int ph = 0; ph < 4; ph++) begin
            tx_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 22 : 73) : 0;
            rx_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 22 : 73) : 0;
            repeat (185) send_instr(random_instr(), 0, none);
        end
        in_ch.valid = 1'b0;

        wait_cycles = 0;
        while (result_q.size() != 0 && wait_cycles < 10000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        if (result_q.size() != 0) begin
            $display("FAIL mips_integer_execute_unit");
            $finish;
        end else begin
            repeat (60) @(posedge i_clk);
            if (!failed) $display("PASS mips_integer_execute_unit");
            else $display("FAIL mips_integer_execute_unit");
            $finish;
        end
    end

endmodule
`default_nettype wire
